### hdl/apr_pkg.sv
`timescale 1ns / 1ps
package apr_pkg;

  localparam int CoordW = 32;
  localparam int WideW  = 64;
  localparam int TrigW  = 34;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] PRE_NONE = 2'd0;
  localparam logic [1:0] PRE_POS  = 2'd1;
  localparam logic [1:0] PRE_NEG  = 2'd2;

  localparam logic signed [TrigW-1:0] KINV    = 34'sd652032874;
  localparam logic signed [TrigW-1:0] Q30_ONE = 34'sd1073741824;

  localparam logic [2:0] ADDR_ROT_AXIS   = 3'd0;
  localparam logic [2:0] ADDR_PLANE_AXIS = 3'd4;

  typedef struct packed {
    logic                     vld;
    logic                     is_ref;
    logic                     unit;
    logic [1:0]               pre;
    logic signed [WideW-1:0]  x;
    logic signed [WideW-1:0]  y;
    logic signed [TrigW-1:0]  c;
    logic signed [TrigW-1:0]  s;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic                     last;
  } apr_item_t;

  function automatic logic signed [CoordW-1:0] coord_sel(
    input logic signed [CoordW-1:0] x,
    input logic signed [CoordW-1:0] y,
    input logic signed [CoordW-1:0] z,
    input logic [1:0] idx
  );
    case (idx)
      AXIS_X:  return x;
      AXIS_Y:  return y;
      default: return z;
    endcase
  endfunction

  // floor of (v + 2^29) / 2^30, saturated to 32 bits
  function automatic logic signed [CoordW-1:0] round_sat(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] r;
    r = (v + 64'sd536870912) >>> 30;
    if (r > 64'sd2147483647) return 32'sh7fffffff;
    if (r < -64'sd2147483648) return 32'sh80000000;
    return r[CoordW-1:0];
  endfunction

endpackage

### hdl/align_point_rotation.sv
`timescale 1ns / 1ps
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// input   | in_valid_i, in_stall_o, mode_i, coord_*_i | in
// output  | out_valid_o, out_stall_i, out_*_o         | out
// config  | psel, penable, pwrite, paddr, pwdata ...  | apb
//
// one beat per cycle while the output is not stalled; a beat passes through the
// prep register, the chain of CORDIC cells, the multiply and round registers
// a reference beat updates cosine/sine as it leaves the last cell, so points
// behind it in the chain use the new angle
// reset puts cosine at 1.0, sine at 0, rotation axis x, plane axis y
// the whole chain halts while a result waits at a stalled output
module align_point_rotation #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic        last_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        out_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import apr_pkg::*;

  // config registers
  logic [1:0] rot_axis_q, plane_axis_q;
  logic       wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_axis_q   <= AXIS_X;
      plane_axis_q <= AXIS_Y;
    end else if (wr_en) begin
      if (paddr[2]) plane_axis_q <= pwdata[1:0];
      else          rot_axis_q   <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2]) prdata[1:0] = plane_axis_q;
    else          prdata[1:0] = rot_axis_q;
  end

  // plane axes and validity; the user keeps them static while beats are in flight, unchecked by the block
  logic [1:0] q1, q2;
  logic       axes_ok;
  assign q1      = plane_axis_q;
  assign q2      = 2'(2'd3 - rot_axis_q - plane_axis_q);
  assign axes_ok = (rot_axis_q != 2'd3) && (plane_axis_q != 2'd3) &&
                   (rot_axis_q != plane_axis_q);

  // global advance: everything moves unless the output is held
  logic adv;
  logic out_vld_q;
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // prep: pick plane pair, scale by 2^30, pre-turn into right half-plane
  apr_item_t prep_d, prep_q;
  logic signed [31:0] pa, pb;
  logic signed [63:0] xa, yb;

  always_comb begin
    pa = coord_sel(coord_x_i, coord_y_i, coord_z_i, q1);
    pb = coord_sel(coord_x_i, coord_y_i, coord_z_i, q2);
    xa = 64'(pa) <<< 30;
    yb = 64'(pb) <<< 30;
    prep_d        = '0;
    prep_d.vld    = in_valid_i;
    prep_d.is_ref = !mode_i;
    prep_d.unit   = !axes_ok || (pa == 32'sd0 && pb == 32'sd0);
    prep_d.pre    = PRE_NONE;
    prep_d.x      = xa;
    prep_d.y      = yb;
    if (xa < 0) begin
      if (yb >= 0) begin
        prep_d.pre = PRE_POS;
        prep_d.x   = yb;
        prep_d.y   = -xa;
      end else begin
        prep_d.pre = PRE_NEG;
        prep_d.x   = -yb;
        prep_d.y   = xa;
      end
    end
    prep_d.c    = KINV;
    prep_d.s    = '0;
    prep_d.px   = coord_x_i;
    prep_d.py   = coord_y_i;
    prep_d.pz   = coord_z_i;
    prep_d.last = last_point_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (adv) begin
      prep_q <= prep_d;
    end
  end

  // chain of CORDIC cells
  apr_item_t chain [CORDIC_STAGES+1];
  assign chain[0] = prep_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    apr_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  apr_item_t tail;
  assign tail = chain[CORDIC_STAGES];

  // undo the pre-turn, clamp, store the angle
  logic signed [TrigW-1:0] cu, su;
  logic signed [31:0]      cos_d, sin_d, cos_q, sin_q;

  always_comb begin
    unique case (tail.pre)
      PRE_POS: begin cu = -tail.s; su = tail.c;  end
      PRE_NEG: begin cu = tail.s;  su = -tail.c; end
      default: begin cu = tail.c;  su = tail.s;  end
    endcase
    if (cu > Q30_ONE)       cu = Q30_ONE;
    else if (cu < -Q30_ONE) cu = -Q30_ONE;
    if (su > Q30_ONE)       su = Q30_ONE;
    else if (su < -Q30_ONE) su = -Q30_ONE;
    cos_d = cu[31:0];
    sin_d = su[31:0];
    if (tail.unit) begin
      cos_d = Q30_ONE[31:0];
      sin_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= Q30_ONE[31:0];
      sin_q <= '0;
    end else if (adv && tail.vld && tail.is_ref) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  // multiply stage: four products, points only
  logic               mul_vld_q;
  logic signed [63:0] ac_q, bs_q, bc_q, as_q;
  logic signed [31:0] mx_q, my_q, mz_q;
  logic               mlast_q;
  logic signed [31:0] ta, tb;

  assign ta = coord_sel(tail.px, tail.py, tail.pz, q1);
  assign tb = coord_sel(tail.px, tail.py, tail.pz, q2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= tail.vld && !tail.is_ref;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ac_q    <= ta * cos_q;
      bs_q    <= tb * sin_q;
      bc_q    <= tb * cos_q;
      as_q    <= ta * sin_q;
      mx_q    <= tail.px;
      my_q    <= tail.py;
      mz_q    <= tail.pz;
      mlast_q <= tail.last;
    end
  end

  // round, saturate, put back into the plane slots
  logic signed [31:0] na, nb, ox_d, oy_d, oz_d;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic               olast_q;

  always_comb begin
    na   = round_sat(ac_q + bs_q);
    nb   = round_sat(bc_q - as_q);
    ox_d = mx_q;
    oy_d = my_q;
    oz_d = mz_q;
    if (axes_ok) begin
      case (q1)
        AXIS_X:  ox_d = na;
        AXIS_Y:  oy_d = na;
        default: oz_d = na;
      endcase
      case (q2)
        AXIS_X:  ox_d = nb;
        AXIS_Y:  oy_d = nb;
        default: oz_d = nb;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      oz_q    <= oz_d;
      olast_q <= mlast_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign out_last_o  = olast_q;

  // a held result blocks the input
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output held");

  // stored angle stays within unit range
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cos_q <= 32'sd1073741824) && (cos_q >= -32'sd1073741824) &&
    (sin_q <= 32'sd1073741824) && (sin_q >= -32'sd1073741824))
    else $error("cosine or sine out of range");

  // angle only changes when a reference beat leaves the chain
  a_angle_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && tail.vld && tail.is_ref) |=> $stable(cos_q) && $stable(sin_q))
    else $error("angle changed without reference beat");

endmodule

### hdl/apr_cell.sv
`timescale 1ns / 1ps
module apr_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  apr_pkg::apr_item_t item_i,
  output apr_pkg::apr_item_t item_o
);
  import apr_pkg::*;

  apr_item_t item_d, item_q;

  // one micro-rotation on reference beats, direction from the sign of y; point beats pass through
  always_comb begin
    item_d = item_i;
    if (item_i.is_ref) begin
      if (item_i.y >= 0) begin
        item_d.x = item_i.x + (item_i.y >>> STAGE);
        item_d.y = item_i.y - (item_i.x >>> STAGE);
        item_d.c = item_i.c - (item_i.s >>> STAGE);
        item_d.s = item_i.s + (item_i.c >>> STAGE);
      end else begin
        item_d.x = item_i.x - (item_i.y >>> STAGE);
        item_d.y = item_i.y + (item_i.x >>> STAGE);
        item_d.c = item_i.c + (item_i.s >>> STAGE);
        item_d.s = item_i.s - (item_i.c >>> STAGE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

### sim/tb_align_point_rotation.sv
`timescale 1ns / 1ps
// pushes reference and point beats through the block under several axis settings
// and checks every rotated point against an in-order model of the cordic math
module tb_align_point_rotation;
  import apr_pkg::*;

  localparam int Stages     = 24;
  localparam int DrainWait  = Stages + 16;   // pipeline depth plus margin
  localparam int WatchLimit = 3000;
  localparam longint QOne   = 64'sd1073741824;
  localparam longint KInv   = 64'sd652032874;

  typedef struct {
    logic               mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } point_beat_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic signed [31:0] cx = '0;
  logic signed [31:0] cy = '0;
  logic signed [31:0] cz = '0;
  logic               last_pt = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] ox, oy, oz;
  logic               olast;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  align_point_rotation #(.CORDIC_STAGES(Stages)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz),
    .last_point_i(last_pt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(ox), .out_y_o(oy), .out_z_o(oz), .out_last_o(olast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: axis registers and the stored reference angle
  logic [1:0] rot_axis = AXIS_X;
  logic [1:0] pln_axis = AXIS_Y;
  longint     cos_q30 = QOne;
  longint     sin_q30 = 0;

  point_beat_t pending_beats[$];
  rotated_t    expected_points[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;      // no idling in the final phase
  int          idle_cycles = 0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit axes_ok();
    return rot_axis <= AXIS_Z && pln_axis <= AXIS_Z && rot_axis != pln_axis;
  endfunction

  // cordic vectoring of (a, b), then store the matching cosine and sine
  function automatic void measure_angle(longint a, longint b);
    longint x, y, c, s, nx, ny, nc, ns;
    int pre;
    pre = 0;
    if (a == 0 && b == 0) begin
      cos_q30 = QOne;
      sin_q30 = 0;
      return;
    end
    x = a * QOne;
    y = b * QOne;
    // left half plane: pre-turn by a quarter
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; pre = 1;
      end else begin
        nx = -y; ny = x; pre = 2;
      end
      x = nx;
      y = ny;
    end
    c = KInv;
    s = 0;
    for (int i = 0; i < Stages; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i);
        nc = c - (s >>> i); ns = s + (c >>> i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i);
        nc = c + (s >>> i); ns = s - (c >>> i);
      end
      x = nx; y = ny; c = nc; s = ns;
    end
    if (pre == 1) begin
      nc = -s; ns = c; c = nc; s = ns;
    end else if (pre == 2) begin
      nc = s; ns = -c; c = nc; s = ns;
    end
    cos_q30 = clamp64(c, -QOne, QOne);
    sin_q30 = clamp64(s, -QOne, QOne);
  endfunction

  function automatic logic signed [31:0] round_q30(longint v);
    return 32'(clamp64((v + 64'sd536870912) >>> 30, -64'sd2147483648, 64'sd2147483647));
  endfunction

  // apply one accepted beat to the model, queue the rotated point if any
  function automatic void align_beat(point_beat_t b);
    longint p[3];
    longint pa, pb;
    int q1, q2;
    rotated_t r;
    p[0] = longint'(b.x);
    p[1] = longint'(b.y);
    p[2] = longint'(b.z);
    q1 = int'(pln_axis);
    q2 = (3 - int'(rot_axis) - int'(pln_axis)) & 3;
    if (!b.mode) begin
      if (axes_ok()) measure_angle(p[q1], p[q2]);
      else begin
        cos_q30 = QOne;
        sin_q30 = 0;
      end
      return;
    end
    if (axes_ok()) begin
      pa = p[q1];
      pb = p[q2];
      p[q1] = longint'(round_q30(pa * cos_q30 + pb * sin_q30));
      p[q2] = longint'(round_q30(pb * cos_q30 - pa * sin_q30));
    end
    r.x = 32'(p[0]);
    r.y = 32'(p[1]);
    r.z = 32'(p[2]);
    r.last = b.last;
    expected_points.push_back(r);
  endfunction

  // input side: sample acceptance on the rising edge
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      align_beat('{mode, cx, cy, cz, last_pt});
      in_taken = 1'b1;
    end
  end

  // input driver: a presented beat holds until taken, then maybe a gap
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        point_beat_t b;
        b = pending_beats.pop_front();
        mode <= b.mode;
        cx <= b.x;
        cy <= b.y;
        cz <= b.z;
        last_pt <= b.last;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall bursts
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && rst_n && $urandom_range(0, 6) == 0) begin
      out_gap <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point beat x=%h y=%h z=%h last=%b", ox, oy, oz, olast);
      end else begin
        rotated_t e;
        e = expected_points.pop_front();
        if (ox !== e.x || oy !== e.y || oz !== e.z || olast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch exp x=%h y=%h z=%h last=%b got x=%h y=%h z=%h last=%b",
                     e.x, e.y, e.z, e.last, ox, oy, oz, olast);
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall) || psel)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ROT_AXIS) rot_axis = data[1:0];
    else if (addr == ADDR_PLANE_AXIS) pln_axis = data[1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh80000000;
      1:       return 32'sh7fffffff;
      2:       return '0;
      3, 4, 5: return $urandom_range(0, 32'h001fffff) - 32'sh00100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_beat(logic m, logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, logic l);
    pending_beats.push_back('{m, x, y, z, l});
  endfunction

  // mostly a reference followed by a point set, sometimes loose beats
  function automatic void add_random_sets(int n);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 7) == 0) begin
        add_beat(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord(),
                 1'($urandom_range(0, 1)));
        cnt++;
      end else begin
        add_beat(1'b0, pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
          add_beat(1'b1, pick_coord(), pick_coord(), pick_coord(), k == len - 1);
        cnt += len + 1;
      end
    end
  endfunction

  // let the block empty out: every point back and the chain idle
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  logic [1:0] rot_set[9] = '{AXIS_Y, AXIS_Z, AXIS_X, AXIS_Z, AXIS_Y, AXIS_Y, 2'd3, AXIS_X,
                              AXIS_X};
  logic [1:0] pln_set[9] = '{AXIS_X, AXIS_X, AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Y, AXIS_Y, 2'd3,
                              AXIS_Y};

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats under the reset axes: zero radius, the left half plane with the
    // second plane coordinate not negative, the extreme coordinates and the end-of-set flag
    add_beat(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 1'b1);
    add_beat(1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    add_beat(1'b1, 32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b0);
    add_beat(1'b0, 32'sh00030000, 32'sh00040000, 32'sh7fffffff, 1'b0);
    add_beat(1'b1, 32'sh00030000, 32'sh00040000, 32'sd5, 1'b1);
    add_beat(1'b0, -32'sh00030000, 32'sh00040000, 32'sd0, 1'b1);
    add_beat(1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0);
    add_beat(1'b1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1);
    add_beat(1'b0, -32'sh00030000, -32'sh00040000, 32'sd0, 1'b0);
    add_beat(1'b1, -32'sh00030000, -32'sh00040000, 32'sd1, 1'b0);
    add_beat(1'b1, 32'sh80000000, 32'sh7fffffff, 32'sd0, 1'b1);
    add_beat(1'b0, 32'sh80000000, 32'sh80000000, 32'sd0, 1'b0);
    add_beat(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    add_beat(1'b0, 32'sh7fffffff, 32'sh80000000, 32'sd0, 1'b1);
    add_beat(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sd0, 1'b1);
    add_beat(1'b0, 32'sh80000000, 32'sd0, 32'sd0, 1'b0);
    add_beat(1'b1, 32'sh00010000, -32'sd1, 32'sd0, 1'b0);
    add_beat(1'b0, 32'sd0, 32'sd1, 32'sd0, 1'b0);
    add_beat(1'b1, 32'sd0, 32'sh00010000, 32'sd0, 1'b1);
    add_random_sets(70);
    drain();

    // sweep the axis settings, including equal axes and axis value three
    foreach (rot_set[i]) begin
      reg_write(ADDR_ROT_AXIS, {30'($urandom_range(0, 32'h3fffffff)), rot_set[i]});
      reg_write(ADDR_PLANE_AXIS, {30'($urandom_range(0, 32'h3fffffff)), pln_set[i]});
      if (i == 8) quiet = 1'b1;
      add_random_sets(i == 8 ? 60 : 80);
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
